// ===== rtl/core/http_get_request_line_tokenizer_unit_macros.svh =====
// ---------------------------------------------------------------------------
// request line tokenizer assertion macros
// shared property shapes for the tokenizer checks, clocked on clk with
// synchronous active-low reset
// ---------------------------------------------------------------------------
`ifndef HTTP_GET_REQUEST_LINE_TOKENIZER_UNIT_MACROS_SVH
`define HTTP_GET_REQUEST_LINE_TOKENIZER_UNIT_MACROS_SVH

// same-cycle implication
`define HGRT_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define HGRT_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/core/hgrt_pkg.sv =====
// ---------------------------------------------------------------------------
// hgrt_pkg
// types, codes and helpers shared by the request line tokenizer
// ---------------------------------------------------------------------------
package hgrt_pkg;

  // default sizing
  localparam int MAX_PARAMS_DEF   = 8;
  localparam int BUFFER_BYTES_DEF = 1024;

  // fixed field widths of a record
  localparam int OFF_W = 10;
  localparam int IDX_W = 3;
  localparam int CNT_W = 4;

  // record queue sizing
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_LVL_W = 3;
  localparam int SLOTS   = 3;

  typedef logic [OFF_W-1:0]   off_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [Q_PTR_W-1:0] q_ptr_t;
  typedef logic [Q_LVL_W-1:0] q_lvl_t;

  // characters of interest
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUERY = 8'h3f;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3d;

  typedef enum logic [1:0] {
    KIND_PATH  = 2'd0,
    KIND_NAME  = 2'd1,
    KIND_VALUE = 2'd2,
    KIND_END   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_GET  = 2'd1,
    ST_TOO_MANY = 2'd2,
    ST_EARLY    = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    kind_t   record_kind;
    idx_t    param_index;
    off_t    start_offset;
    off_t    token_length;
    status_t status;
    cnt_t    param_count;
    logic    last_of_run;
  } rec_t;

  // records raised by one byte, slot 0 first
  typedef struct packed {
    logic [1:0]       cnt;
    rec_t [SLOTS-1:0] rec;
  } rec_set_t;

  function automatic logic [7:0] method_char(logic [1:0] pos);
    logic [7:0] ch;
    case (pos)
      2'd0:    ch = CH_G;
      2'd1:    ch = CH_E;
      2'd2:    ch = CH_T;
      default: ch = CH_SPACE;
    endcase
    return ch;
  endfunction

  function automatic rec_t mk_rec(kind_t kind, idx_t idx, off_t start, off_t len,
                                  status_t st, cnt_t cnt);
    rec_t r;
    r.record_kind  = kind;
    r.param_index  = idx;
    r.start_offset = start;
    r.token_length = len;
    r.status       = st;
    r.param_count  = cnt;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

endpackage

// ===== rtl/core/hgrt_parse.sv =====
// ---------------------------------------------------------------------------
// hgrt_parse
// tokenizer state and record generation for one held byte
// ---------------------------------------------------------------------------
module hgrt_parse #(
  parameter int MAX_PARAMS   = hgrt_pkg::MAX_PARAMS_DEF,
  parameter int BUFFER_BYTES = hgrt_pkg::BUFFER_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  hgrt_pkg::in_beat_t beat,
  input  logic               advance,
  output hgrt_pkg::rec_set_t rec_set
);
  import hgrt_pkg::*;

  localparam int OW = $clog2(BUFFER_BYTES + 1);
  localparam int PW = $clog2(MAX_PARAMS + 1);

  typedef logic [OW-1:0] bo_t;
  typedef logic [PW-1:0] pc_t;

  localparam bo_t BUF_LIMIT  = bo_t'(BUFFER_BYTES);
  localparam pc_t PARAM_LIM  = pc_t'(MAX_PARAMS);
  localparam bo_t PATH_START = bo_t'(4);

  bo_t        off_r,  off_nxt;
  logic [1:0] sp_r,   sp_nxt;
  pc_t        ps_r,   ps_nxt;
  bo_t        pb_r,   pb_nxt;
  logic       pcl_r,  pcl_nxt;
  bo_t        nb_r,   nb_nxt;
  bo_t        vb_r,   vb_nxt;
  logic       vo_r,   vo_nxt;
  logic       fin_r,  fin_nxt;

  logic [7:0]       c;
  logic [1:0]       k;
  rec_t [SLOTS-1:0] recs;

  assign c = beat.data_byte;

  always_comb begin
    k       = 2'd0;
    recs    = '0;
    off_nxt = off_r;
    sp_nxt  = sp_r;
    ps_nxt  = ps_r;
    pb_nxt  = pb_r;
    pcl_nxt = pcl_r;
    nb_nxt  = nb_r;
    vb_nxt  = vb_r;
    vo_nxt  = vo_r;
    fin_nxt = fin_r;

    if (!fin_r) begin
      if (off_r >= BUF_LIMIT) begin
        recs[k] = mk_rec(KIND_END, '0, '0, '0, ST_EARLY, cnt_t'(ps_r));
        k       = k + 2'd1;
        fin_nxt = 1'b1;
      end else if (off_r < PATH_START) begin
        if (c != method_char(off_r[1:0])) begin
          recs[k] = mk_rec(KIND_END, '0, '0, '0, ST_NOT_GET, '0);
          k       = k + 2'd1;
          fin_nxt = 1'b1;
        end else if (off_r == bo_t'(3)) begin
          sp_nxt = 2'd1;
          pb_nxt = PATH_START;
        end
      end else if (c == CH_SPACE || c == CH_QUERY || c == CH_AMP) begin
        // path closes at the closing space or the first question mark
        if (!pcl_r && c != CH_AMP) begin
          recs[k] = mk_rec(KIND_PATH, '0, off_t'(pb_r), off_t'(off_r - pb_r), ST_OK, '0);
          k       = k + 2'd1;
          pcl_nxt = 1'b1;
        end
        // close a value whose equals sign was seen
        if (vo_r) begin
          recs[k] = mk_rec(KIND_VALUE, idx_t'(ps_r - pc_t'(1)), off_t'(vb_r),
                           off_t'(off_r - vb_r), ST_OK, '0);
          k       = k + 2'd1;
          vo_nxt  = 1'b0;
        end
        if (c == CH_SPACE) begin
          sp_nxt  = 2'd2;
          recs[k] = mk_rec(KIND_END, '0, '0, '0, ST_OK, cnt_t'(ps_r));
          k       = k + 2'd1;
          fin_nxt = 1'b1;
        end else if (ps_r >= PARAM_LIM) begin
          recs[k] = mk_rec(KIND_END, '0, '0, '0, ST_TOO_MANY, cnt_t'(MAX_PARAMS));
          k       = k + 2'd1;
          fin_nxt = 1'b1;
        end else begin
          ps_nxt = ps_r + pc_t'(1);
          nb_nxt = off_r + bo_t'(1);
        end
      end else if (c == CH_EQ) begin
        // ignored while the path is still open
        if (pcl_r && ps_r != '0) begin
          recs[k] = mk_rec(KIND_NAME, idx_t'(ps_r - pc_t'(1)), off_t'(nb_r),
                           off_t'(off_r - nb_r), ST_OK, '0);
          k       = k + 2'd1;
          vb_nxt  = off_r + bo_t'(1);
          vo_nxt  = 1'b1;
        end
      end

      if (!fin_nxt) begin
        off_nxt = off_r + bo_t'(1);
      end
      if (beat.last_byte && !fin_nxt) begin
        recs[k] = mk_rec(KIND_END, '0, '0, '0, (sp_nxt == 2'd0) ? ST_NOT_GET : ST_EARLY,
                         cnt_t'(ps_nxt));
        k       = k + 2'd1;
        fin_nxt = 1'b1;
      end
    end

    if (k != 2'd0) begin
      recs[k - 2'd1].last_of_run = 1'b1;
    end

    // final byte returns everything to its reset value
    if (beat.last_byte) begin
      off_nxt = '0;
      sp_nxt  = '0;
      ps_nxt  = '0;
      pb_nxt  = '0;
      pcl_nxt = 1'b0;
      nb_nxt  = '0;
      vb_nxt  = '0;
      vo_nxt  = 1'b0;
      fin_nxt = 1'b0;
    end
  end

  assign rec_set.cnt = k;
  assign rec_set.rec = recs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r <= '0;
      sp_r  <= '0;
      ps_r  <= '0;
      pb_r  <= '0;
      pcl_r <= 1'b0;
      nb_r  <= '0;
      vb_r  <= '0;
      vo_r  <= 1'b0;
      fin_r <= 1'b0;
    end else if (advance) begin
      off_r <= off_nxt;
      sp_r  <= sp_nxt;
      ps_r  <= ps_nxt;
      pb_r  <= pb_nxt;
      pcl_r <= pcl_nxt;
      nb_r  <= nb_nxt;
      vb_r  <= vb_nxt;
      vo_r  <= vo_nxt;
      fin_r <= fin_nxt;
    end
  end

endmodule

// ===== rtl/core/hgrt_rec_q.sv =====
// ---------------------------------------------------------------------------
// hgrt_rec_q
// small record queue, takes up to three records a cycle, gives one while out_stall is low
// ---------------------------------------------------------------------------
module hgrt_rec_q (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_en,
  input  hgrt_pkg::rec_set_t push_set,
  output logic               out_valid,
  output hgrt_pkg::rec_t     out_rec,
  input  logic               out_stall,
  output hgrt_pkg::q_lvl_t   level
);
  import hgrt_pkg::*;

  rec_t   q_r [Q_DEPTH];
  q_ptr_t wr_ptr_r, wr_ptr_nxt;
  q_ptr_t rd_ptr_r, rd_ptr_nxt;
  q_lvl_t lvl_r,    lvl_nxt;
  q_lvl_t push_n;
  logic   pop;

  assign out_valid = (lvl_r != '0);
  assign out_rec   = q_r[rd_ptr_r];
  assign level     = lvl_r;
  assign pop       = out_valid && !out_stall;
  assign push_n    = push_en ? q_lvl_t'(push_set.cnt) : '0;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + q_ptr_t'(push_n);
    rd_ptr_nxt = rd_ptr_r + q_ptr_t'(pop);
    lvl_nxt    = lvl_r + push_n - q_lvl_t'(pop);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < SLOTS; i++) begin
      if (push_en && (i < int'(push_set.cnt))) begin
        q_r[q_ptr_t'(wr_ptr_r + q_ptr_t'(i))] <= push_set.rec[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      lvl_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      lvl_r    <= lvl_nxt;
    end
  end

endmodule

// ===== rtl/core/http_get_request_line_tokenizer_unit.sv =====
// ---------------------------------------------------------------------------
// http_get_request_line_tokenizer_unit
// splits a GET request line into path, parameter name and value records
// ---------------------------------------------------------------------------
// Takes a request buffer one byte per beat (last_byte flags the final byte)
// and emits records: the path, a name record at each '=' after the path,
// a value record when a value is closed by '&', '?' or the closing space,
// and one end status record (ok, not GET, too many parameters, ended early).
// Bytes after the end are swallowed until the final byte, after which all
// state returns to reset. Rate: one byte per cycle while each byte raises at
// most one record and out_stall is low; the output port drains one record
// per cycle while not stalled, so a run of bytes raising two or three records
// each is held to the record rate, with a four-deep record queue absorbing
// short bursts. A byte's records pass the input register, then the queue.
// ---------------------------------------------------------------------------
`include "http_get_request_line_tokenizer_unit_macros.svh"

module http_get_request_line_tokenizer_unit #(
  parameter int MAX_PARAMS   = hgrt_pkg::MAX_PARAMS_DEF,
  parameter int BUFFER_BYTES = hgrt_pkg::BUFFER_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // byte input
  input  logic               in_valid,
  output logic               in_stall,
  input  hgrt_pkg::in_beat_t in_beat,
  // record output
  output logic               out_valid,
  input  logic               out_stall,
  output hgrt_pkg::rec_t     out_beat
);
  import hgrt_pkg::*;

  // input register
  logic     hold_valid_r;
  in_beat_t hold_beat_r;

  // parse results and queue status
  rec_set_t rec_set;
  q_lvl_t   q_level;
  logic     room;
  logic     advance;

  // a held byte moves on only when all of its records fit in the queue;
  // room is judged on the registered fill level, so stall on the input
  // never waits on the output stall in the same cycle
  assign room     = (q_lvl_t'(Q_DEPTH) - q_level) >= q_lvl_t'(rec_set.cnt);
  assign advance  = hold_valid_r && room;
  assign in_stall = hold_valid_r && !room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (!in_stall) begin
      hold_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_beat_r <= in_beat;
    end
  end

  // tokenizer state and record generation
  hgrt_parse #(
    .MAX_PARAMS   (MAX_PARAMS),
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .beat    (hold_beat_r),
    .advance (advance),
    .rec_set (rec_set)
  );

  // records wait here until the output side takes them
  hgrt_rec_q u_rec_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (advance),
    .push_set  (rec_set),
    .out_valid (out_valid),
    .out_rec   (out_beat),
    .out_stall (out_stall),
    .level     (q_level)
  );

  // checks

  // the queue never fills past its depth
  `HGRT_ASSERT_NOW(a_level_bound, 1'b1, q_level <= q_lvl_t'(Q_DEPTH), "record queue overfilled")

  // an end record always closes the run of records for its byte
  `HGRT_ASSERT_NOW(a_end_closes_run, out_valid && out_beat.record_kind == KIND_END,
    out_beat.last_of_run, "end record without last_of_run")

  // a byte that raises no record never grows the queue
  `HGRT_ASSERT_NEXT(a_quiet_byte, advance && rec_set.cnt == 2'd0,
    q_level <= $past(q_level), "queue grew on a byte with no records")

endmodule
